[src/som_pkg.sv]
// Shared constants, state type and arithmetic helpers of the map engine.
`timescale 1ns / 1ps
package som_pkg;

  localparam int MAP_SIDE  = 16;
  localparam int DIMS      = 8;
  localparam int ELEM_BITS = 16;
  localparam int NODES     = MAP_SIDE * MAP_SIDE;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int NODE_W    = DIMS * ELEM_BITS;
  localparam int DIST_W    = 43;
  localparam int MUL_AW    = 32;
  localparam int MUL_BW    = 17;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int DIV_NW    = 41;
  localparam int DIV_DW    = 32;
  localparam int DIV_QW    = 9;

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_CLASSIFY = 2'd1;
  localparam logic [1:0] ACT_TRAIN    = 2'd2;

  localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_DIMS_IN_USE = 2'd2;
  localparam logic [1:0] CFG_DIM_WEIGHTS = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LDIV, ST_SRD, ST_DSQ, ST_DWT, ST_DEND,
    ST_PGO, ST_PDIV, ST_PEXM, ST_PEXC, ST_S2M, ST_S2C,
    ST_NSET, ST_SQM, ST_SQC, ST_AGO, ST_ADIV, ST_NEM, ST_NEC,
    ST_FM, ST_FC, ST_UM, ST_UC, ST_UWR, ST_RES
  } state_t;

  // round(65536 * exp(-n))
  function automatic logic [16:0] int_exp(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // round(65536 * exp(-k/16))
  function automatic logic [16:0] frac_exp(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sq4(input logic [3:0] v);
    return {4'b0, v} * {4'b0, v};
  endfunction

  // (p + 0.5) >> 16, saturated to 16 bits
  function automatic logic [15:0] rnd16(input logic [MUL_PW-1:0] p);
    logic [33:0] s;
    s = {1'b0, p[32:0]} + 34'd32768;
    if (s[33:16] > 18'd65535) return 16'hFFFF;
    return s[31:16];
  endfunction

endpackage

[src/som_if.sv]
// Channel interfaces: config write, input word and result word.
`timescale 1ns / 1ps
interface som_cfg_if import som_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface som_in_if import som_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [NODE_AW-1:0]   node_index;
  logic [ELEM_BITS-1:0] elem0;
  logic [ELEM_BITS-1:0] elem1;
  logic [ELEM_BITS-1:0] elem2;
  logic [ELEM_BITS-1:0] elem3;
  logic [ELEM_BITS-1:0] elem4;
  logic [ELEM_BITS-1:0] elem5;
  logic [ELEM_BITS-1:0] elem6;
  logic [ELEM_BITS-1:0] elem7;
  logic [15:0]          iteration_index;
  logic [15:0]          iteration_count;
  modport source(output valid, action, node_index, elem0, elem1, elem2, elem3, elem4,
                 elem5, elem6, elem7, iteration_index, iteration_count, input ready);
  modport sink(input valid, action, node_index, elem0, elem1, elem2, elem3, elem4,
               elem5, elem6, elem7, iteration_index, iteration_count, output ready);
endinterface

interface som_out_if import som_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        best_x;
  logic [3:0]        best_y;
  logic [DIST_W-1:0] best_distance;
  modport source(output valid, best_x, best_y, best_distance, input ready);
  modport sink(input valid, best_x, best_y, best_distance, output ready);
endinterface

[src/som_node_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module som_node_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[src/som_mul.sv]
// Shared 32x17 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module som_mul import som_pkg::*; (
  input  logic              clk,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [MUL_PW-1:0] p
);
  logic [MUL_PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {{MUL_BW{1'b0}}, a} * {{MUL_AW{1'b0}}, b};
  end

  assign p = p_r;
endmodule

[src/som_div.sv]
// Restoring divider, one quotient bit a cycle, quotient saturated at 256.
`timescale 1ns / 1ps
module som_div import som_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_QW-1:0] q
);
  logic              busy_r;
  logic              done_r;
  logic              sat_r;
  logic [3:0]        step_r;
  logic [DIV_NW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [7:0]        q_r;
  logic [DIV_NW-1:0] shifted;
  logic              ge;

  assign shifted = {{(DIV_NW-DIV_DW){1'b0}}, den_r} << step_r;
  assign ge      = rem_r >= shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && ((step_r == 4'd8 && ge) || step_r == 4'd0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      step_r <= 4'd8;
      q_r    <= 8'd0;
      sat_r  <= 1'b0;
    end else if (busy_r) begin
      if (step_r == 4'd8) begin
        // quotient of 256 or more clamps
        if (ge) sat_r <= 1'b1;
        else step_r <= 4'd7;
      end else begin
        if (ge) begin
          rem_r            <= rem_r - shifted;
          q_r[step_r[2:0]] <= 1'b1;
        end
        if (step_r != 4'd0) step_r <= step_r - 4'd1;
      end
    end
  end

  assign done = done_r;
  assign q    = sat_r ? 9'd256 : {1'b0, q_r};
endmodule

[src/som_best_match_and_train.sv]
// Kohonen map engine: node store, best-match scan and training sequencer.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------
//  cfg_chan | in  | valid / ready | register index, 64-bit write data
//  in_chan  | in  | valid / ready | action, node_index, elem0..7, iteration
//  out_chan | out | valid / ready | best_x, best_y, best_distance
//
// Work per word, accept to next accept, over the nodes and dims in use:
//   load     row of the node by repeated subtraction; off the map past the last row
//   classify scans all nodes in use; the shared multiplier squares and weights each dim
//   train    classify, then each node updated; sqrt and divide run bit-serially,
//            a saturating divide, sigma^2 of zero or the best-match node itself is shorter
// Reset (rst_n low, synchronous) restores the config registers; node store is not
// cleared. in_chan.ready is high only in idle; a finished result stalls only while
// the output register still holds an unaccepted word, and the next word is taken
// once the result has moved into the output register.
`timescale 1ns / 1ps
module som_best_match_and_train import som_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  som_cfg_if.sink    cfg_chan,
  som_in_if.sink     in_chan,
  som_out_if.source  out_chan
);
  // config
  logic [4:0]  width_r, height_r;
  logic [3:0]  dims_r;
  logic [63:0] weights_r;
  logic [4:0]  w_c, h_c;
  logic [3:0]  dims_c;
  logic [3:0]  w_m1, h_m1;

  state_t state_r, state_nxt;

  // latched word
  logic [1:0]           act_r;
  logic [NODE_AW-1:0]   idx_r;
  logic [ELEM_BITS-1:0] vec_r [DIMS];
  logic [15:0]          iter_r, total_r;

  // scan / train
  logic [NODE_AW-1:0]   i_r;
  logic [3:0]           x_r, y_r, bx_r, by_r;
  logic [2:0]           k_r;
  logic [DIST_W-1:0]    sum_r, best_d_r;
  logic [NODE_AW-1:0]   rem_r;
  logic [4:0]           ly_r;
  logic [15:0]          lr_r, nb_r, f_r;
  logic [31:0]          s2_r;
  logic [8:0]           t_r, root_r;
  logic [3:0]           bit_r;
  logic [16:0]          v_r;
  logic [ELEM_BITS-1:0] upd_r [DIMS];
  logic [3:0]           res_x_r, res_y_r;
  logic [DIST_W-1:0]    res_d_r;

  // output register
  logic              out_valid_r;
  logic [3:0]        out_x_r, out_y_r;
  logic [DIST_W-1:0] out_d_r;

  // datapath nets
  logic                 in_acc, out_load;
  logic                 last_node, last_dim;
  logic [ELEM_BITS-1:0] node_el, in_el, adiff, delta;
  logic [7:0]           wk;
  logic [3:0]           dx, dy;
  logic [8:0]           trial;
  logic [DIST_W-1:0]    tot;
  logic                 win;
  logic                 ld_fit, ld_out;
  logic [15:0]          total_c;

  // unit ports
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] div_q;
  logic              ram_we, ram_re;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr;
  logic [NODE_W-1:0]  ram_wdata, ram_rdata, vec_pack, upd_pack;

  som_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  som_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  som_node_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // ---------------- config port ----------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 5'd16;
      height_r  <= 5'd16;
      dims_r    <= 4'd8;
      weights_r <= 64'h1010101010101010;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_MAP_WIDTH:   width_r   <= cfg_chan.data[4:0];
        CFG_MAP_HEIGHT:  height_r  <= cfg_chan.data[4:0];
        CFG_DIMS_IN_USE: dims_r    <= cfg_chan.data[3:0];
        CFG_DIM_WEIGHTS: weights_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize clamps to the map / vector size
  assign w_c    = (width_r == 5'd0) ? 5'd1 : ((width_r > 5'd16) ? 5'd16 : width_r);
  assign h_c    = (height_r == 5'd0) ? 5'd1 : ((height_r > 5'd16) ? 5'd16 : height_r);
  assign dims_c = (dims_r == 4'd0) ? 4'd1 : ((dims_r > 4'd8) ? 4'd8 : dims_r);
  assign w_m1   = 4'(w_c - 5'd1);
  assign h_m1   = 4'(h_c - 5'd1);

  // ---------------- datapath nets ----------------
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == ST_RES) && (!out_valid_r || out_chan.ready);

  assign last_node = (x_r == w_m1) && (y_r == h_m1);
  assign last_dim  = ({1'b0, k_r} == 4'(dims_c - 4'd1));

  assign node_el = ram_rdata[{k_r, 4'b0} +: ELEM_BITS];
  assign in_el   = vec_r[k_r];
  assign adiff   = (node_el > in_el) ? node_el - in_el : in_el - node_el;
  assign wk      = weights_r[{k_r, 3'b0} +: 8];
  assign delta   = rnd16(mul_p);

  assign dx    = (x_r > bx_r) ? x_r - bx_r : bx_r - x_r;
  assign dy    = (y_r > by_r) ? y_r - by_r : by_r - y_r;
  assign trial = root_r | (9'd1 << bit_r);

  assign tot = sum_r + mul_p[DIST_W-1:0];
  assign win = (i_r == '0) || (tot < best_d_r);

  assign ld_out = (ly_r == h_c);
  assign ld_fit = !ld_out && (rem_r < {3'b0, w_c});

  assign total_c = (total_r == 16'd0) ? 16'd1 : total_r;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      vec_pack[d*ELEM_BITS +: ELEM_BITS] = vec_r[d];
      upd_pack[d*ELEM_BITS +: ELEM_BITS] = upd_r[d];
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_chan.action == ACT_LOAD) ? ST_LDIV : ST_SRD;
      ST_LDIV: if (ld_out || ld_fit) state_nxt = ST_RES;
      ST_SRD:  state_nxt = ST_DSQ;
      ST_DSQ:  state_nxt = ST_DWT;
      ST_DWT:  state_nxt = last_dim ? ST_DEND : ST_DSQ;
      ST_DEND: begin
        if (!last_node) state_nxt = ST_DSQ;
        else state_nxt = (act_r == ACT_TRAIN) ? ST_PGO : ST_RES;
      end
      ST_PGO:  state_nxt = ST_PDIV;
      ST_PDIV: if (div_done) state_nxt = ST_PEXM;
      ST_PEXM: state_nxt = ST_PEXC;
      ST_PEXC: state_nxt = ST_S2M;
      ST_S2M:  state_nxt = ST_S2C;
      ST_S2C:  state_nxt = ST_NSET;
      ST_NSET: state_nxt = (dx == 4'd0 && dy == 4'd0) ? ST_NEM : ST_SQM;
      ST_SQM:  state_nxt = ST_SQC;
      ST_SQC: begin
        if (bit_r != 4'd0) state_nxt = ST_SQM;
        else state_nxt = (s2_r == 32'd0) ? ST_NEM : ST_AGO;
      end
      ST_AGO:  state_nxt = ST_ADIV;
      ST_ADIV: if (div_done) state_nxt = ST_NEM;
      ST_NEM:  state_nxt = ST_NEC;
      ST_NEC:  state_nxt = ST_FM;
      ST_FM:   state_nxt = ST_FC;
      ST_FC:   state_nxt = ST_UM;
      ST_UM:   state_nxt = ST_UC;
      ST_UC:   state_nxt = last_dim ? ST_UWR : ST_UM;
      ST_UWR:  state_nxt = last_node ? ST_RES : ST_NSET;
      ST_RES:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // ---------------- sequencer: unit controls ----------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = vec_pack;
    ram_re    = 1'b0;
    ram_raddr = i_r;
    case (state_r)
      ST_LDIV: ram_we = ld_fit;
      ST_SRD:  ram_re = 1'b1;
      ST_DSQ: begin
        mul_a = {16'b0, adiff};
        mul_b = {1'b0, adiff};
      end
      ST_DWT: begin
        mul_a = mul_p[31:0];
        mul_b = {9'b0, wk};
      end
      ST_DEND: begin
        ram_re    = !last_node;
        ram_raddr = i_r + 1'b1;
      end
      ST_PGO: begin
        // p in Q.4: (iteration + 1) * 16 / count
        div_start = 1'b1;
        div_num   = {20'b0, ({1'b0, iter_r} + 17'd1), 4'b0};
        div_den   = {16'b0, total_c};
      end
      ST_PEXM, ST_NEM: begin
        mul_a = {15'b0, frac_exp(t_r[3:0])};
        mul_b = int_exp(t_r[7:4]);
      end
      ST_S2M: begin
        mul_a = {16'b0, lr_r};
        mul_b = {1'b0, lr_r};
      end
      ST_NSET: ram_re = 1'b1;
      ST_SQM: begin
        mul_a = {23'b0, trial};
        mul_b = {8'b0, trial};
      end
      ST_AGO: begin
        // grid distance over 2 sigma^2: (d4 << 31) / s2
        div_start = 1'b1;
        div_num   = {1'b0, root_r, 31'b0};
        div_den   = s2_r;
      end
      ST_FM: begin
        mul_a = {16'b0, lr_r};
        mul_b = {1'b0, nb_r};
      end
      ST_UM: begin
        mul_a = {16'b0, adiff};
        mul_b = {1'b0, f_r};
      end
      ST_UWR: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = upd_pack;
      end
      default: ;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_r    <= in_chan.action;
          idx_r    <= in_chan.node_index;
          vec_r[0] <= in_chan.elem0;
          vec_r[1] <= in_chan.elem1;
          vec_r[2] <= in_chan.elem2;
          vec_r[3] <= in_chan.elem3;
          vec_r[4] <= in_chan.elem4;
          vec_r[5] <= in_chan.elem5;
          vec_r[6] <= in_chan.elem6;
          vec_r[7] <= in_chan.elem7;
          iter_r   <= in_chan.iteration_index;
          total_r  <= in_chan.iteration_count;
          rem_r    <= in_chan.node_index;
          ly_r     <= 5'd0;
          i_r      <= '0;
          x_r      <= 4'd0;
          y_r      <= 4'd0;
          k_r      <= 3'd0;
          sum_r    <= '0;
        end
      end
      ST_LDIV: begin
        // row = index / width by repeated subtraction; past last row = off map
        if (ld_out) begin
          res_x_r <= 4'd0;
          res_y_r <= 4'd0;
          res_d_r <= '0;
        end else if (ld_fit) begin
          res_x_r <= rem_r[3:0];
          res_y_r <= ly_r[3:0];
          res_d_r <= '0;
        end else begin
          rem_r <= rem_r - {3'b0, w_c};
          ly_r  <= ly_r + 5'd1;
        end
      end
      ST_DSQ: if (k_r != 3'd0) sum_r <= tot;
      ST_DWT: if (!last_dim) k_r <= k_r + 3'd1;
      ST_DEND: begin
        if (win) begin
          best_d_r <= tot;
          bx_r     <= x_r;
          by_r     <= y_r;
        end
        if (!last_node) begin
          i_r   <= i_r + 1'b1;
          x_r   <= (x_r == w_m1) ? 4'd0 : x_r + 4'd1;
          y_r   <= (x_r == w_m1) ? y_r + 4'd1 : y_r;
          k_r   <= 3'd0;
          sum_r <= '0;
        end else begin
          res_x_r <= win ? x_r : bx_r;
          res_y_r <= win ? y_r : by_r;
          res_d_r <= win ? tot : best_d_r;
        end
      end
      ST_PDIV: if (div_done) t_r <= div_q;
      ST_PEXC: lr_r <= t_r[8] ? 16'd0 : rnd16(mul_p);
      ST_S2C: begin
        s2_r <= mul_p[31:0];
        i_r  <= '0;
        x_r  <= 4'd0;
        y_r  <= 4'd0;
      end
      ST_NSET: begin
        v_r    <= {({1'b0, sq4(dx)} + {1'b0, sq4(dy)}), 8'b0};
        root_r <= 9'd0;
        bit_r  <= 4'd8;
        if (dx == 4'd0 && dy == 4'd0) t_r <= 9'd0;
      end
      ST_SQC: begin
        // one root bit a pass; sigma^2 of zero saturates the exponent
        if (mul_p <= {{(MUL_PW-17){1'b0}}, v_r}) root_r <= trial;
        if (bit_r != 4'd0) bit_r <= bit_r - 4'd1;
        else if (s2_r == 32'd0) t_r <= 9'd256;
      end
      ST_ADIV: if (div_done) t_r <= div_q;
      ST_NEC:  nb_r <= t_r[8] ? 16'd0 : rnd16(mul_p);
      ST_FC: begin
        f_r <= rnd16(mul_p);
        k_r <= 3'd0;
        for (int d = 0; d < DIMS; d++) begin
          upd_r[d] <= ram_rdata[d*ELEM_BITS +: ELEM_BITS];
        end
      end
      ST_UC: begin
        upd_r[k_r] <= (in_el >= node_el) ? node_el + delta : node_el - delta;
        if (!last_dim) k_r <= k_r + 3'd1;
      end
      ST_UWR: begin
        if (!last_node) begin
          i_r <= i_r + 1'b1;
          x_r <= (x_r == w_m1) ? 4'd0 : x_r + 4'd1;
          y_r <= (x_r == w_m1) ? y_r + 4'd1 : y_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
      out_d_r <= res_d_r;
    end
  end

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.best_x        = out_x_r;
  assign out_chan.best_y        = out_y_r;
  assign out_chan.best_distance = out_d_r;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer idle right after taking a word");

  a_coord_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DSQ || state_r == ST_DEND || state_r == ST_NSET || state_r == ST_UWR)
    |-> ({1'b0, x_r} < w_c) && ({1'b0, y_r} < h_c))
    else $error("node coordinate outside map");

  a_dim_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DWT || state_r == ST_UC) |-> ({1'b0, k_r} < dims_c))
    else $error("dimension counter beyond dims in use");

  a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RES)
    else $error("result word raised outside result state");
endmodule

[tb/som_checker.sv]
// Map engine checker: tracks config and node store, predicts and compares result words.
`timescale 1ns / 1ps
module som_checker import som_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  som_cfg_if   cfg_chan,
  som_in_if    in_chan,
  som_out_if   out_chan,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [3:0]        bx;
    logic [3:0]        by;
    logic [DIST_W-1:0] dsum;
  } match_t;

  logic [4:0]           width_reg;
  logic [4:0]           height_reg;
  logic [3:0]           dims_reg;
  logic [63:0]          weight_reg;
  logic [ELEM_BITS-1:0] node_mem [NODES][DIMS];
  match_t               match_q[$];

  localparam longint unsigned INT_TAB [16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                               22, 8, 3, 1, 0, 0, 0, 0};
  localparam longint unsigned FRAC_TAB [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                                45042, 42313, 39750, 37341, 35079, 32954,
                                                30957, 29081, 27319, 25664};

  function automatic longint unsigned clip(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // exp(-t/16) in Q0.16, t in Q.4
  function automatic longint unsigned decay(longint unsigned t);
    longint unsigned n, r;
    n = t >> 4;
    if (n >= 16) return 0;
    r = (INT_TAB[n] * FRAC_TAB[t & 15] + 32768) >> 16;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b, t;
    r = 0;
    for (b = 64'd1 << 20; b != 0; b >>= 1) begin
      t = r | b;
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // best match search, or node write on load; on action train also pulls the map toward the word
  function automatic match_t match_and_train(logic [1:0] act, logic [7:0] idx,
                                             logic [ELEM_BITS-1:0] vec [DIMS],
                                             logic [15:0] iter, logic [15:0] total);
    longint unsigned w, h, dims, cnt, best, best_d, d, df, wt, p4, lr, s2, bx, by;
    longint unsigned dx, dy, d4, a4, f, nv, iv;
    match_t m;
    w = clip(width_reg, MAP_SIDE);
    h = clip(height_reg, MAP_SIDE);
    dims = clip(dims_reg, DIMS);
    cnt = w * h;
    m = '0;
    if (act == ACT_LOAD) begin
      if (idx < cnt) begin
        for (int k = 0; k < DIMS; k++) node_mem[idx][k] = vec[k];
        m.bx = 4'(idx % w);
        m.by = 4'(idx / w);
      end
      return m;
    end
    best = 0;
    best_d = 0;
    for (longint unsigned i = 0; i < cnt; i++) begin
      d = 0;
      for (longint unsigned k = 0; k < dims; k++) begin
        df = (node_mem[i][k] > vec[k]) ? node_mem[i][k] - vec[k] : vec[k] - node_mem[i][k];
        wt = (weight_reg >> (8 * k)) & 8'hFF;
        d += df * df * wt;
      end
      if (i == 0 || d < best_d) begin
        best = i;
        best_d = d;
      end
    end
    m.bx = 4'(best % w);
    m.by = 4'(best / w);
    m.dsum = DIST_W'(best_d);
    if (act == ACT_TRAIN) begin
      if (total == 0) total = 1;
      p4 = ((longint'(iter) + 1) * 16) / total;
      lr = decay(p4);
      s2 = lr * lr;
      bx = best % w;
      by = best / w;
      for (longint unsigned i = 0; i < cnt; i++) begin
        dx = (i % w > bx) ? i % w - bx : bx - i % w;
        dy = (i / w > by) ? i / w - by : by - i / w;
        d4 = root((dx * dx + dy * dy) * 256);
        if (d4 == 0) a4 = 0;
        else if (s2 == 0) a4 = 256;
        else begin
          a4 = (d4 << 31) / s2;
          if (a4 > 256) a4 = 256;
        end
        f = (lr * decay(a4) + 32768) >> 16;
        for (longint unsigned k = 0; k < dims; k++) begin
          nv = node_mem[i][k];
          iv = vec[k];
          if (iv >= nv) nv += ((iv - nv) * f + 32768) >> 16;
          else nv -= ((nv - iv) * f + 32768) >> 16;
          node_mem[i][k] = nv[ELEM_BITS-1:0];
        end
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin
    logic [ELEM_BITS-1:0] vec [DIMS];
    match_t got, want, pred;
    if (!rst_n) begin
      width_reg  <= 5'd16;
      height_reg <= 5'd16;
      dims_reg   <= 4'd8;
      weight_reg <= 64'h1010101010101010;
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_MAP_WIDTH:   width_reg <= cfg_chan.data[4:0];
          CFG_MAP_HEIGHT:  height_reg <= cfg_chan.data[4:0];
          CFG_DIMS_IN_USE: dims_reg <= cfg_chan.data[3:0];
          CFG_DIM_WEIGHTS: weight_reg <= cfg_chan.data;
          default: ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.best_x, out_chan.best_y, out_chan.best_distance};
        if (match_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word x=%0d y=%0d dist=%0d", got.bx, got.by, got.dsum);
        end else begin
          want = match_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected x=%0d y=%0d dist=%0d, got x=%0d y=%0d dist=%0d",
                       want.bx, want.by, want.dsum, got.bx, got.by, got.dsum);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        vec = '{in_chan.elem0, in_chan.elem1, in_chan.elem2, in_chan.elem3,
                in_chan.elem4, in_chan.elem5, in_chan.elem6, in_chan.elem7};
        // action three acts as classify
        pred = match_and_train(in_chan.action == ACT_LOAD ? ACT_LOAD :
                               in_chan.action == ACT_TRAIN ? ACT_TRAIN :
                               ACT_CLASSIFY, in_chan.node_index, vec,
                               in_chan.iteration_index, in_chan.iteration_count);
        match_q = {match_q, pred};
      end
      pending = match_q.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: stimulus, handshake pressure, timeout and verdict for the map engine.
`timescale 1ns / 1ps
module tb;
  import som_pkg::*;

  typedef struct {
    logic [1:0]           action;
    logic [7:0]           node_index;
    logic [ELEM_BITS-1:0] elem [DIMS];
    logic [15:0]          iter;
    logic [15:0]          total;
  } word_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   words_sent;
  int   map_nodes;   // nodes in use under the current config

  som_cfg_if cfg_chan();
  som_in_if  in_chan();
  som_out_if out_chan();

  som_best_match_and_train u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_chan),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  som_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: the limit lies far above the slowest run, a train on a full map.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("som_best_match_and_train regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, an occasional long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls with stall-free stretches, plus one long
  // hold-off after 30 results so that the engine backs up and drops in ready.
  initial begin
    int mode_left, seen, hold;
    bit stall_free;
    mode_left = 0;
    seen = 0;
    hold = 0;
    stall_free = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (out_chan.valid && out_chan.ready) seen++;
      if (seen == 30 && hold == 0) hold = 3000;
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        stall_free = ($urandom_range(0, 2) == 0);
      end
      mode_left--;
      if (hold > 1) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (stall_free) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= (gap_len() == 0);
      end
    end
  end

  // Called right after an accept edge (or at start); leaves valid high.
  task automatic send_word(word_t w, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid           <= 1'b1;
    in_chan.action          <= w.action;
    in_chan.node_index      <= w.node_index;
    in_chan.elem0           <= w.elem[0];
    in_chan.elem1           <= w.elem[1];
    in_chan.elem2           <= w.elem[2];
    in_chan.elem3           <= w.elem[3];
    in_chan.elem4           <= w.elem[4];
    in_chan.elem5           <= w.elem[5];
    in_chan.elem6           <= w.elem[6];
    in_chan.elem7           <= w.elem[7];
    in_chan.iteration_index <= w.iter;
    in_chan.iteration_count <= w.total;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Idle engine only: drain first, then write all four registers.
  task automatic set_map(logic [4:0] w, logic [4:0] h, logic [3:0] d, logic [63:0] wts);
    int cw, ch;
    drain();
    cfg_write(CFG_MAP_WIDTH, {$urandom, 27'd0, w});
    cfg_write(CFG_MAP_HEIGHT, {$urandom, 27'd0, h});
    cfg_write(CFG_DIMS_IN_USE, {$urandom, 28'd0, d});
    cfg_write(CFG_DIM_WEIGHTS, wts);
    cw = (w == 0) ? 1 : (w > MAP_SIDE) ? MAP_SIDE : w;
    ch = (h == 0) ? 1 : (h > MAP_SIDE) ? MAP_SIDE : h;
    map_nodes = cw * ch;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t make_word(logic [1:0] act);
    word_t w;
    w.action = act;
    w.node_index = 8'($urandom_range(0, map_nodes - 1));
    foreach (w.elem[k]) w.elem[k] = rand_elem();
    // mostly a real schedule, sometimes arbitrary or past its end
    case ($urandom_range(0, 5))
      0: begin
        w.total = 16'($urandom);
        w.iter = 16'($urandom);
      end
      1: begin
        w.total = 16'($urandom_range(0, 8));
        w.iter = 16'(w.total + $urandom_range(0, 40));
      end
      default: begin
        w.total = 16'($urandom_range(1, 40));
        w.iter = 16'($urandom_range(0, w.total - 1));
      end
    endcase
    return w;
  endfunction

  // Every node in use gets written before any scan reads it.
  task automatic load_map();
    word_t w;
    for (int i = 0; i < map_nodes; i++) begin
      w = make_word(ACT_LOAD);
      w.node_index = 8'(i);
      send_word(w, gap_len());
    end
  endtask

  initial begin
    word_t w;
    logic [63:0] wts;
    int r;
    rst_n = 1'b0;
    words_sent = 0;
    map_nodes = NODES;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= CFG_MAP_WIDTH;
    cfg_chan.data  <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.action <= ACT_LOAD;
    in_chan.node_index <= '0;
    in_chan.elem0 <= '0;
    in_chan.elem1 <= '0;
    in_chan.elem2 <= '0;
    in_chan.elem3 <= '0;
    in_chan.elem4 <= '0;
    in_chan.elem5 <= '0;
    in_chan.elem6 <= '0;
    in_chan.elem7 <= '0;
    in_chan.iteration_index <= '0;
    in_chan.iteration_count <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: 2x2 map, max weights, all dims.
    set_map(5'd2, 5'd2, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    // two identical all-zero nodes and two all-ones nodes: ties go to lowest index
    for (int i = 0; i < 4; i++) begin
      w = make_word(ACT_LOAD);
      w.node_index = 8'(i);
      foreach (w.elem[k]) w.elem[k] = (i < 2) ? 16'h0000 : 16'hFFFF;
      send_word(w, 0);
    end
    w = make_word(ACT_CLASSIFY);
    foreach (w.elem[k]) w.elem[k] = 16'h0000;
    send_word(w, 0);                               // exact hit, tie at nodes 0 and 1
    foreach (w.elem[k]) w.elem[k] = 16'h7FFF;
    send_word(w, 1);                               // nearer the zero nodes
    foreach (w.elem[k]) w.elem[k] = 16'hFFFF;
    w.action = 2'd3;                               // action three classifies
    send_word(w, 0);
    w.action = ACT_LOAD;
    w.node_index = 8'd4;                           // just outside the map
    send_word(w, 0);
    w.node_index = 8'hFF;
    send_word(w, 0);
    w.action = ACT_TRAIN;
    w.iter = 16'd0;
    w.total = 16'd1;                               // first epoch of one
    send_word(w, 0);
    w.total = 16'd0;                               // count zero counts as one
    send_word(w, 2);
    w.iter = 16'hFFFF;
    w.total = 16'd1;                               // far past the end: factors vanish
    send_word(w, 0);
    w.iter = 16'd0;
    w.total = 16'hFFFF;                            // early in a long schedule
    foreach (w.elem[k]) w.elem[k] = 16'h5555;
    send_word(w, 0);
    w.action = ACT_CLASSIFY;
    send_word(w, 0);

    // Register extremes: zero sizes, oversize width and dims, zero weights, full map.
    set_map(5'd0, 5'd0, 4'd0, 64'h0);
    load_map();
    send_word(make_word(ACT_TRAIN), 0);
    send_word(make_word(ACT_CLASSIFY), 0);
    set_map(5'd31, 5'd2, 4'd15, {$urandom, $urandom});
    load_map();
    repeat (6) send_word(make_word(2'($urandom_range(1, 2))), gap_len());
    set_map(5'd16, 5'd16, 4'd8, {$urandom, $urandom});
    load_map();
    repeat (2) send_word(make_word(ACT_TRAIN), gap_len());
    send_word(make_word(ACT_CLASSIFY), 0);
    send_word(make_word(ACT_LOAD), 0);

    // Random phases on small maps.
    while (words_sent < 1000) begin
      case ($urandom_range(0, 3))
        0:       wts = 64'h1010101010101010;
        1:       wts = {8{8'($urandom_range(0, 1) ? 8'hFF : 8'h00)}};
        default: wts = {$urandom, $urandom};
      endcase
      set_map(5'($urandom_range(0, 5)), 5'($urandom_range(0, 5)),
              4'($urandom_range(0, 15)), wts);
      load_map();
      for (int n = 0; n < 60; n++) begin
        if (n == 30 && $urandom_range(0, 3) == 0) drain();  // sender waits out all results
        r = $urandom_range(0, 99);
        if (r < 25) w = make_word(ACT_LOAD);
        else if (r < 30) begin
          w = make_word(ACT_LOAD);
          w.node_index = 8'($urandom);              // often off the map: ignored
        end else if (r < 35) w = make_word(2'd3);
        else if (r < 65) w = make_word(ACT_CLASSIFY);
        else w = make_word(ACT_TRAIN);
        send_word(w, gap_len());
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("som_best_match_and_train regression: pass");
    end else begin
      $display("som_best_match_and_train regression: fail");
    end
    $finish;
  end

endmodule

[som_best_match_and_train.f]
src/som_pkg.sv
src/som_if.sv
src/som_node_ram.sv
src/som_mul.sv
src/som_div.sv
src/som_best_match_and_train.sv
tb/som_checker.sv
tb/tb.sv
